FILE: sv/upd_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
`default_nettype none

package upd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Escape phase of the front end.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One classified request: up to three output bytes, emitted ch0 first.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] ch2;
        logic [7:0] ch1;
        logic [7:0] ch0;
        logic       str_end;
    } job_t;

    // Queue status as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_ZERO + 8'd9) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5);
    endfunction

    // Value of a character already known to be a hex digit. Letters of either
    // case carry their offset from 'A' or 'a', plus one, in the low nibble.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        if (c <= CH_ZERO + 8'd9)
        begin
            v = c[3:0];
        end
        else
        begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/upd_front.sv
// Front part: accepts raw bytes, tracks escape state and builds output requests.
`default_nettype none

module upd_front
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // string_end
    input  wire q_status_t  q_stat,
    output logic            push,
    output job_t            push_job
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [7:0] c;
    logic       hex;
    logic       pct_hold;
    logic       accept;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign c        = (s_tdata == CH_PLUS) ? CH_SPACE : s_tdata;
    assign hex      = is_hex(c);
    // A percent sign opens an escape unless it is the final byte.
    assign pct_hold = (c == CH_PERCENT) && !s_tlast;

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (hex && !s_tlast)
                    begin
                        phase_next = PH_DIGIT;
                        held_next  = c;
                    end
                    else
                    begin
                        phase_next = pct_hold ? PH_PCT : PH_IDLE;
                    end
                end
                PH_DIGIT:
                begin
                    if (hex)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = pct_hold ? PH_PCT : PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = pct_hold ? PH_PCT : PH_IDLE;
                end
            endcase
        end
    end

    // Request contents.
    always_comb
    begin
        push_job         = '0;
        push_job.str_end = s_tlast;
        case (phase_reg)
            PH_PCT:
            begin
                if (!(hex && !s_tlast))
                begin
                    push_job.ch0 = CH_PERCENT;
                    if (pct_hold)
                    begin
                        push_job.count = 2'd1;
                    end
                    else
                    begin
                        push_job.ch1   = c;
                        push_job.count = 2'd2;
                    end
                end
            end
            PH_DIGIT:
            begin
                if (hex)
                begin
                    push_job.ch0   = {hex_nibble(held_reg), hex_nibble(c)};
                    push_job.count = 2'd1;
                end
                else
                begin
                    push_job.ch0 = CH_PERCENT;
                    push_job.ch1 = held_reg;
                    if (pct_hold)
                    begin
                        push_job.count = 2'd2;
                    end
                    else
                    begin
                        push_job.ch2   = c;
                        push_job.count = 2'd3;
                    end
                end
            end
            default:
            begin
                if (!pct_hold)
                begin
                    push_job.ch0   = c;
                    push_job.count = 2'd1;
                end
            end
        endcase
    end

    assign push = accept && (push_job.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/upd_queue.sv
// Short request queue between the front and back parts.
`default_nettype none

module upd_queue
    import upd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output q_status_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t            mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/upd_back.sv
// Back part: takes requests from the queue and emits their bytes one per cycle unless stalled.
`default_nettype none

module upd_back
    import upd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire job_t       head,
    input  wire q_status_t  q_stat,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // string_last
    output logic            m_tuser    // run_last
);

    job_t       cur_reg, cur_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       last;
    logic       advance;

    assign last    = (idx_reg == cur_reg.count - 2'd1);
    assign advance = !valid_reg || (m_tready && last);
    assign pop     = advance && !q_stat.empty;

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_tdata = cur_reg.ch0;
            2'd1:    m_tdata = cur_reg.ch1;
            default: m_tdata = cur_reg.ch2;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = last;
    assign m_tlast  = last && cur_reg.str_end;

    always_comb
    begin
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = !q_stat.empty;
            cur_next   = head;
            idx_next   = 2'd0;
        end
        else if (m_tready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.count != 2'd0))
        else $error("request in service has no bytes");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < cur_reg.count))
        else $error("byte index past end of request");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && (idx_reg == 2'd0)))
        else $error("popped request not started at its first byte");

endmodule

`default_nettype wire

FILE: sv/url_percent_decoder.sv
// URL percent decoder: front classifier, request queue and byte emitter.
// A result is first written as a request into the queue and then loaded into the back
// part's registers, which present it on the output. Throughput: one input request per
// cycle while each produces at most one byte and the output is ready; the emitter gives
// one byte per cycle, so invalid escapes of two or three bytes fill the queue.
// Reset: rst_n is asynchronous and active low; it clears escape state, queue and output.
`default_nettype none

module url_percent_decoder
    import upd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // string_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // string_last
    output logic            m_tuser    // run_last
);

    // The front part decides, for each accepted byte, which bytes must be
    // emitted (none while an escape is still pending) and writes them as one
    // request into the queue. The back part then plays each request out a
    // byte at a time, so a stalled output never blocks the escape tracking
    // until the queue is full.
    job_t      push_job;
    job_t      head;
    logic      push;
    logic      pop;
    q_status_t q_stat;

    upd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // The queue depth sets how many requests may pile up before
    // the input is held off.
    upd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    // The back part holds the request in service in registers, which act as
    // the output stage of the block.
    upd_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

FILE: test/url_percent_decoder_tb.sv
// Self-checking testbench for the URL percent decoder, driven with random stalls.
`timescale 1ns / 100ps

module url_percent_decoder_tb;
    import upd_pkg::*;

    localparam int RANDOM_BYTES = 120;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 80;

    // One decoded byte together with its two marker flags.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       str_last;
    } decoded_t;

    // Keeps its own copy of the escape state, works out the decoded bytes for
    // every accepted request and compares what leaves the block against them.
    class decode_scoreboard;
        phase_t     phase;
        logic [7:0] held_digit;
        decoded_t   expected_q[$];
        decoded_t   run_q[$];
        int         mismatches;

        function new();
            phase      = PH_IDLE;
            held_digit = '0;
            mismatches = 0;
        endfunction

        // Value of a hex digit of either case, or -1 for any other byte.
        function int digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
            begin
                return int'(c - CH_ZERO);
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5)
            begin
                return int'(c - CH_UPPER_A) + 10;
            end
            if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5)
            begin
                return int'(c - CH_LOWER_A) + 10;
            end
            return -1;
        endfunction

        function void push_byte(logic [7:0] b);
            decoded_t d;
            d.data     = b;
            d.run_last = 1'b0;
            d.str_last = 1'b0;
            run_q.push_back(d);
        endfunction

        // A byte with no escape pending: a percent sign opens one, unless the
        // string ends there, in which case it goes out as it is.
        function void take_literal(logic [7:0] c, logic fin);
            if (c == CH_PERCENT && !fin)
            begin
                phase = PH_PCT;
            end
            else
            begin
                push_byte(c);
            end
        endfunction

        function void note_encoded(logic [7:0] raw, logic fin);
            logic [7:0] c;
            logic [7:0] b;
            int         v;
            int         h;
            phase_t     was;
            run_q.delete();
            c   = (raw == CH_PLUS) ? CH_SPACE : raw;
            was = phase;
            phase = PH_IDLE;
            v   = digit_value(c);
            case (was)
                PH_PCT:
                begin
                    if (v >= 0 && !fin)
                    begin
                        held_digit = c;
                        phase      = PH_DIGIT;
                    end
                    else
                    begin
                        push_byte(CH_PERCENT);
                        take_literal(c, fin);
                    end
                end
                PH_DIGIT:
                begin
                    if (v >= 0)
                    begin
                        h = digit_value(held_digit);
                        if (h < 0)
                        begin
                            h = 0;
                        end
                        b = 8'(h * 16 + v);
                        push_byte(b);
                    end
                    else
                    begin
                        push_byte(CH_PERCENT);
                        push_byte(held_digit);
                        take_literal(c, fin);
                    end
                end
                default:
                begin
                    take_literal(c, fin);
                end
            endcase
            if (run_q.size() > 0)
            begin
                run_q[run_q.size() - 1].run_last = 1'b1;
                if (fin)
                begin
                    run_q[run_q.size() - 1].str_last = 1'b1;
                end
            end
            foreach (run_q[i])
            begin
                expected_q.push_back(run_q[i]);
            end
        endfunction

        function void check_decoded(logic [7:0] b, logic rl, logic sl);
            decoded_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected output byte %02h run_last %0b string_last %0b",
                             b, rl, sl);
                end
                return;
            end
            e = expected_q.pop_front();
            if (e.data !== b || e.run_last !== rl || e.str_last !== sl)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Expected byte %02h run_last %0b string_last %0b, got %02h %0b %0b",
                             e.data, e.run_last, e.str_last, b, rl, sl);
                end
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;    // in_byte
    logic       s_tlast = 1'b0;     // string_end
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // out_byte
    logic       m_tlast;            // string_last
    logic       m_tuser;            // run_last

    decode_scoreboard board = new();

    // quiet switches off idling on both sides for a whole string; hold_long asks
    // the receiver for one long hold-off, and hold_active is raised while it lasts.
    bit quiet = 1'b0;
    bit hold_long = 1'b0;
    bit hold_active = 1'b0;
    int bytes_sent = 0;
    int cycles = 0;

    url_percent_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Guard against a hung block: the slowest correct run is far below this.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offers one request after a random gap and waits for it to be taken. The
    // handshake is sampled at the edge, before the block's own updates land.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = (quiet || hold_active) ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        board.note_encoded(b, fin);
        bytes_sent++;
    endtask

    // Sends a whole string, marking its final byte as the end of the string.
    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], i == s.len() - 1);
        end
    endtask

    // Picks a random hex digit, in upper or lower case.
    function automatic logic [7:0] random_digit();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
        begin
            return CH_ZERO + 8'(r);
        end
        if (r < 16)
        begin
            return CH_UPPER_A + 8'(r - 10);
        end
        return CH_LOWER_A + 8'(r - 16);
    endfunction

    // Builds a string mostly out of well-formed escapes and plain bytes, with
    // some broken escapes mixed in. A string may well end in the middle of an
    // escape, which exercises the cut-short case.
    task automatic send_random_string();
        logic [7:0] s[$];
        int         tokens;
        tokens = $urandom_range(1, 6);
        repeat (tokens)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: s.push_back(8'($urandom_range(0, 255)));
                3:       s.push_back(CH_PLUS);
                4, 5, 6:
                begin
                    s.push_back(CH_PERCENT);
                    s.push_back(random_digit());
                    s.push_back(random_digit());
                end
                7:
                begin
                    s.push_back(CH_PERCENT);
                    s.push_back(8'($urandom_range(0, 255)));
                end
                8:
                begin
                    s.push_back(CH_PERCENT);
                    s.push_back(random_digit());
                    s.push_back(8'($urandom_range(0, 255)));
                end
                default: s.push_back(CH_PERCENT);
            endcase
        end
        foreach (s[i])
        begin
            send_byte(s[i], i == s.size() - 1);
        end
    endtask

    // Stops offering and waits until every expected byte has left the block.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (board.expected_q.size() > 0);
    endtask

    // Receiver: draws a stall before each byte, or serves a long hold-off when
    // one has been asked for, so that the internal queue fills up.
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long   = 1'b0;
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_active = 1'b0;
            end
            else
            begin
                n = quiet ? 0 : $urandom_range(0, 7);
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_decoded(m_tdata, m_tuser, m_tlast);
        end
    end

    initial
    begin
        int random_start;
        int strings;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Extreme byte values and a plus sign in one string.
        send_byte(8'h00, 1'b0);
        send_byte(CH_PLUS, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Valid escapes with upper, lower and mixed case digits.
        send_text("%41%6f%aC");
        // A decoded percent sign must not start a new escape; then a bad second byte.
        send_text("%25%G");
        // Bad third byte, a percent sign straight after a percent sign, and a
        // lone percent sign as the final byte.
        send_text("%ax%%41%");
        // Escape cut short by the end of the string after one digit.
        send_text("%F");
        // A plus sign inside an escape is still mapped to a space.
        send_text("%+z");
        wait_drained();

        // Random part, with one long hold-off and one full drain on the way.
        random_start = bytes_sent;
        strings = 0;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            if (strings == 5)
            begin
                hold_long = 1'b1;
            end
            if (strings == 10)
            begin
                wait_drained();
            end
            send_random_string();
            strings++;
        end
        quiet = 1'b0;

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.mismatches == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
